>>> design/chts_pkg.sv
// ----------------------------------------------------------------------------
// chts_pkg: shared types and constants of the chained hash table store
// Status codes, the stored entry layout and the key normalization function.
// ----------------------------------------------------------------------------
package chts_pkg;

  // Width of the key and value fields.
  localparam int KeyW   = 24;
  localparam int ValueW = 32;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_ARG   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Request commands.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One stored entry: normalized key and its value.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } entry_t;

  // Keep only the first len bytes, and stop at the first zero byte.
  function automatic logic [KeyW-1:0] normalize_key(input logic [KeyW-1:0] raw,
                                                     input logic [3:0]      len);
    logic [KeyW-1:0] k;
    logic            live;
    k    = '0;
    live = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (4'(i) >= len || raw[8*i +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        k[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return k;
  endfunction

endpackage

>>> design/chained_hash_table_store.sv
// ----------------------------------------------------------------------------
// chained_hash_table_store: key-value store in fixed hash buckets
// Add or look up a key in a caller-chosen bucket of BUCKET_DEPTH entries.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready  | command, bucket, key, key_length,
//          |           |                      | value_in
//  out     | output    | out_valid / out_ready| status, value_out
//
//  A request goes from acceptance through a fill-count read and a scan that
//  compares n (1 to BUCKET_DEPTH) bucket entries to the done state; entries are
//  read one per cycle from the single read port of the entry memory. A rejected
//  request goes from acceptance straight to the done state. One request is in
//  work at a time; the next is accepted once the result has moved to the output
//  register, even while that result waits. Reset clears the per-bucket valid
//  bits at once, so no clearing pass is needed.
module chained_hash_table_store #(
  parameter int NUM_BUCKETS  = 8,
  parameter int BUCKET_DEPTH = 4,
  parameter int KEY_BYTES    = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [7:0]         bucket,
  input  logic [23:0]        key,
  input  logic [3:0]         key_length,
  input  logic signed [31:0] value_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] value_out
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NE = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW = (NE > 1) ? $clog2(NE) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;

  // Request registers.
  logic                       cmd_q;
  logic [BW-1:0]              bucket_q;
  logic [chts_pkg::KeyW-1:0]  key_q;
  logic [31:0]                value_q;
  logic [AW-1:0]              base_q;
  logic [FW-1:0]              fill_q;
  logic [FW-1:0]              idx;
  logic [2:0]                 res_status;
  logic [31:0]                res_value;

  // Memories.
  logic [FW-1:0]          fill_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] fill_valid;
  logic [FW-1:0]          fill_rdata;
  logic                   fill_rvalid;
  chts_pkg::entry_t       ent_mem [NE];
  chts_pkg::entry_t       ent_rdata;

  logic             accept;
  logic             bad_arg;
  logic [BW-1:0]    fill_raddr;
  logic [AW-1:0]    ent_raddr;
  logic             ent_we;
  logic [AW-1:0]    ent_waddr;
  chts_pkg::entry_t ent_wdata;
  logic             fill_we;
  logic             match;
  logic             last;
  logic             bucket_full;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Argument check on the incoming request.
  assign bad_arg = ({1'b0, bucket} >= 9'(NUM_BUCKETS)) || (key_length > 4'(KEY_BYTES));

  // Read addresses: fill count at acceptance, then entries one by one.
  assign fill_raddr = bucket[BW-1:0];
  assign ent_raddr  = (state == S_FILL) ? base_q : base_q + AW'(idx + FW'(1));

  // Compare the entry just read against the request key.
  assign match       = (idx < fill_q) && (ent_rdata.key == key_q);
  assign last        = ({1'b0, idx} + (FW+1)'(1)) >= {1'b0, fill_q};
  assign bucket_full = (fill_q == FW'(BUCKET_DEPTH));

  // Write-back decisions made in the scan state.
  always_comb begin
    ent_we    = 1'b0;
    fill_we   = 1'b0;
    ent_waddr = base_q + AW'(idx);
    ent_wdata = '{key: key_q, value: value_q};
    if (state == S_SCAN && cmd_q == chts_pkg::CMD_ADD) begin
      if (match) begin
        ent_we = 1'b1;
      end else if (last && !bucket_full) begin
        ent_we    = 1'b1;
        fill_we   = 1'b1;
        ent_waddr = base_q + AW'(fill_q);
      end
    end
  end

  // Fill count memory with per-bucket valid bits.
  always_ff @(posedge clk) begin
    fill_rdata <= fill_mem[fill_raddr];
    if (fill_we) begin
      fill_mem[bucket_q] <= fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_valid  <= '0;
      fill_rvalid <= 1'b0;
    end else begin
      fill_rvalid <= fill_valid[fill_raddr];
      if (fill_we) begin
        fill_valid[bucket_q] <= 1'b1;
      end
    end
  end

  // Entry memory: one read port, one write port.
  always_ff @(posedge clk) begin
    ent_rdata <= ent_mem[ent_raddr];
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= bad_arg ? S_DONE : S_FILL;
          end
        end
        S_FILL: state <= S_SCAN;
        S_SCAN: begin
          if (match || last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request payload and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= command;
      bucket_q   <= bucket[BW-1:0];
      key_q      <= chts_pkg::normalize_key(key, key_length);
      value_q    <= value_in;
      base_q     <= AW'(bucket[BW-1:0]) * AW'(BUCKET_DEPTH);
      res_status <= chts_pkg::ST_BAD_ARG;
      res_value  <= '0;
    end
    if (state == S_FILL) begin
      fill_q <= fill_rvalid ? fill_rdata : '0;
      idx    <= '0;
    end
    if (state == S_SCAN) begin
      idx <= idx + FW'(1);
      if (match) begin
        if (cmd_q == chts_pkg::CMD_LOOKUP) begin
          res_status <= chts_pkg::ST_FOUND;
          res_value  <= ent_rdata.value;
        end else begin
          res_status <= chts_pkg::ST_UPDATED;
        end
      end else if (last) begin
        if (cmd_q == chts_pkg::CMD_LOOKUP) begin
          res_status <= chts_pkg::ST_NOT_FOUND;
        end else if (bucket_full) begin
          res_status <= chts_pkg::ST_FULL;
        end else begin
          res_status <= chts_pkg::ST_INSERTED;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status    <= res_status;
      value_out <= res_value;
    end
  end

endmodule

>>> design/chts_checker.sv
// ----------------------------------------------------------------------------
// chts_checker: port-level checks of the chained hash table store
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module chts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         status,
  input logic signed [31:0] value_out
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out))
    else $error("result changed while stalled");

  // Only a found result carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != chts_pkg::ST_FOUND |-> value_out == 32'sd0)
    else $error("nonzero value on a result other than found");

  // Status is always a defined code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= chts_pkg::ST_FULL)
    else $error("undefined status code");

  // One request at a time: the block is busy the cycle after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind chained_hash_table_store chts_checker u_chts_checker (.*);
